### design/est_pkg.sv
package est_pkg;

	localparam int unsigned TIME_WIDTH_DEF = 48;
	localparam int unsigned ADDR_WIDTH = 5;
	localparam int unsigned DATA_WIDTH = 32;

	localparam logic [16:0] ONE_FX = 17'd65536;
	localparam logic [11:0] ON_THRESHOLD = 12'd1700;
	localparam logic [16:0] CRANK_THRUST = 17'd6554;
	localparam logic [16:0] IDLE_FLOOR = 17'd655;
	// 5 * demand <= 1.0
	localparam logic [16:0] START_DEMAND_MAX = 17'd13107;
	localparam logic [31:0] CHOKE_LIMIT_US = 32'd1000000;
	localparam logic [31:0] OVERHEAT_US = 32'd3000000;
	localparam logic [12:0] RPM_BASE = 13'd1000;
	localparam logic [12:0] RPM_SPAN = 13'd6000;
	localparam logic [13:0] SLEW_RESET = 14'd100;

	// step = floor(slew * dt * 2^16 / 1e8) = floor(slew * dt * 2^8 / 5^8).
	// Taken as (prod * M) >> 46 with M = ceil(2^54 / 5^8) = 46116860185,
	// exact for prod < 2^27; M is split in two 18-bit halves.
	localparam int unsigned DT_BITS = 27;
	localparam int unsigned RECIP_SPLIT = 18;
	localparam int unsigned RECIP_SHIFT = 46;
	localparam logic [17:0] SLEW_RECIP_HI = 18'd175921;
	localparam logic [17:0] SLEW_RECIP_LO = 18'd225561;

	typedef enum logic [2:0] {
		REG_RPM_FAILURE      = 3'd0,
		REG_SLEW             = 3'd1,
		REG_STARTER_PRESENT  = 3'd2,
		REG_IGNITION_PRESENT = 3'd3,
		REG_CHOKE_PRESENT    = 3'd4,
		REG_GEARBOX_PRESENT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic        rpm_failure;
		logic [13:0] slew_percent_per_s;
		logic        starter_present;
		logic        ignition_present;
		logic        choke_present;
		logic        gearbox_present;
	} est_cfg_t;

endpackage

### design/est_regs.sv
module est_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [est_pkg::ADDR_WIDTH-1:0]   paddr,
	input  logic [est_pkg::DATA_WIDTH-1:0]   pwdata,
	output logic [est_pkg::DATA_WIDTH-1:0]   prdata,
	output logic                             pready,
	output est_pkg::est_cfg_t                cfg
);
	import est_pkg::*;

	est_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_failure        <= 1'b0;
			cfg_q.slew_percent_per_s <= SLEW_RESET;
			cfg_q.starter_present    <= 1'b0;
			cfg_q.ignition_present   <= 1'b0;
			cfg_q.choke_present      <= 1'b0;
			cfg_q.gearbox_present    <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_RPM_FAILURE:      cfg_q.rpm_failure        <= pwdata[0];
				REG_SLEW:             cfg_q.slew_percent_per_s <= pwdata[13:0];
				REG_STARTER_PRESENT:  cfg_q.starter_present    <= pwdata[0];
				REG_IGNITION_PRESENT: cfg_q.ignition_present   <= pwdata[0];
				REG_CHOKE_PRESENT:    cfg_q.choke_present      <= pwdata[0];
				REG_GEARBOX_PRESENT:  cfg_q.gearbox_present    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_RPM_FAILURE:      prdata[0]    = cfg_q.rpm_failure;
			REG_SLEW:             prdata[13:0] = cfg_q.slew_percent_per_s;
			REG_STARTER_PRESENT:  prdata[0]    = cfg_q.starter_present;
			REG_IGNITION_PRESENT: prdata[0]    = cfg_q.ignition_present;
			REG_CHOKE_PRESENT:    prdata[0]    = cfg_q.choke_present;
			REG_GEARBOX_PRESENT:  prdata[0]    = cfg_q.gearbox_present;
			default:              prdata       = '0;
		endcase
	end

endmodule

### design/engine_start_throttle_model.sv
// An accepted input transaction passes through stages 1 to 4 and the output register to the output.
// Throughput: one transaction per cycle while the output is not stalled; the engine state
// (power, start and overheat) is updated in the last stage, where the slew step from the
// pipelined multiply is applied. Stages hold when the output is stalled and empty stages
// fill, so input is taken while a result waits. Reset clears the engine state, the time
// stamp and all valid bits; the registers come up at their documented values.
module engine_start_throttle_model #(
	parameter int unsigned TIME_WIDTH = est_pkg::TIME_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [est_pkg::ADDR_WIDTH-1:0]   paddr,
	input  logic [est_pkg::DATA_WIDTH-1:0]   pwdata,
	output logic [est_pkg::DATA_WIDTH-1:0]   prdata,
	output logic                             pready,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [TIME_WIDTH-1:0]            now_us,
	input  logic [16:0]                      demand,
	input  logic [11:0]                      starter_pwm,
	input  logic                             starter_pwm_ok,
	input  logic [11:0]                      ignition_pwm,
	input  logic                             ignition_pwm_ok,
	input  logic [11:0]                      choke_pwm,
	input  logic                             choke_pwm_ok,
	input  logic                             park_or_neutral,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [16:0]                      power_out,
	output logic [12:0]                      rpm,
	output logic                             overheat,
	output logic                             running
);
	import est_pkg::*;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] now;
		logic [16:0]           demand;
		logic                  starter_on;
		logic                  ign_off;
		logic                  choke_on;
		logic                  park;
	} item_t;

	est_cfg_t cfg;

	est_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------- pipeline control ----------------
	logic v_s1, v_s2, v_s3, v_s4, result_valid_q;
	logic load_s1, load_s2, load_s3, load_s4, load_out;
	logic accept;

	assign load_out   = !result_valid_q || !result_stall;
	assign load_s4    = !v_s4 || load_out;
	assign load_s3    = !v_s3 || load_s4;
	assign load_s2    = !v_s2 || load_s3;
	assign load_s1    = !v_s1 || load_s2;
	assign item_stall = !load_s1;
	assign accept     = item_valid && load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_s1)  v_s1           <= item_valid;
			if (load_s2)  v_s2           <= v_s1;
			if (load_s3)  v_s3           <= v_s2;
			if (load_s4)  v_s4           <= v_s3;
			if (load_out) result_valid_q <= v_s4;
		end
	end

	// ---------------- stage 1: decode, time since last transaction ----------------
	logic [TIME_WIDTH-1:0] last_stamp_q;
	logic [TIME_WIDTH-1:0] dt;
	item_t                 item_in;
	item_t                 item_s1, item_s2, item_s3, item_s4;
	logic [DT_BITS-1:0]    dt_lo_s1;
	logic                  dt_big_s1;

	assign dt = now_us - last_stamp_q;

	always_comb begin
		item_in.now        = now_us;
		item_in.demand     = (demand > ONE_FX) ? ONE_FX : demand;
		item_in.starter_on = starter_pwm_ok && (starter_pwm > ON_THRESHOLD);
		item_in.ign_off    = cfg.ignition_present && ignition_pwm_ok &&
		                     !(ignition_pwm > ON_THRESHOLD);
		item_in.choke_on   = cfg.choke_present && choke_pwm_ok && (choke_pwm > ON_THRESHOLD);
		item_in.park       = park_or_neutral;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
		end else if (accept && cfg.starter_present) begin
			last_stamp_q <= now_us;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1   <= item_in;
			dt_lo_s1  <= dt[DT_BITS-1:0];
			dt_big_s1 <= |dt[TIME_WIDTH-1:DT_BITS];
		end
	end

	// ---------------- stage 2: slew * dt, rpm ----------------
	logic [DT_BITS+13:0] prod_c, prod_s2;
	logic                sat_s2;
	logic [29:0]         rpm_prod;
	logic [12:0]         rpm_c, rpm_s2, rpm_s3, rpm_s4;

	assign prod_c   = cfg.slew_percent_per_s * dt_lo_s1;
	assign rpm_prod = item_s1.demand * RPM_SPAN;
	assign rpm_c    = cfg.rpm_failure ? 13'd0 : RPM_BASE + rpm_prod[28:16];

	always_ff @(posedge clk) begin
		if (load_s2) begin
			item_s2 <= item_s1;
			prod_s2 <= prod_c;
			sat_s2  <= dt_big_s1;
			rpm_s2  <= rpm_c;
		end
	end

	// ---------------- stage 3: reciprocal partial products ----------------
	logic [DT_BITS+RECIP_SPLIT-1:0] pp_hi_s3, pp_lo_s3;
	logic                           sat_s3, zero_s3;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			item_s3  <= item_s2;
			pp_hi_s3 <= prod_s2[DT_BITS-1:0] * SLEW_RECIP_HI;
			pp_lo_s3 <= prod_s2[DT_BITS-1:0] * SLEW_RECIP_LO;
			sat_s3   <= sat_s2 || (|prod_s2[DT_BITS+13:DT_BITS]);
			zero_s3  <= (cfg.slew_percent_per_s == '0);
			rpm_s3   <= rpm_s2;
		end
	end

	// ---------------- stage 4: slew step ----------------
	localparam int unsigned SUM_W = DT_BITS + 2 * RECIP_SPLIT;
	logic [SUM_W-1:0] recip_sum;
	logic [16:0]      quot;
	logic [16:0]      step_c, step_s4;

	assign recip_sum = {pp_hi_s3, {RECIP_SPLIT{1'b0}}} + SUM_W'(pp_lo_s3);
	assign quot      = recip_sum[RECIP_SHIFT+16:RECIP_SHIFT];

	always_comb begin
		if (zero_s3)
			step_c = '0;
		else if (sat_s3 || quot > ONE_FX)
			step_c = ONE_FX;
		else
			step_c = quot;
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			item_s4 <= item_s3;
			step_s4 <= step_c;
			rpm_s4  <= rpm_s3;
		end
	end

	// ---------------- output stage: engine state update ----------------
	logic [16:0]           last_power_q, power_n;
	logic [TIME_WIDTH-1:0] start_stamp_q, start_n;
	logic                  overheat_q, overheat_n;
	logic [TIME_WIDTH-1:0] run_time;
	logic                  choke_trip, crank_long, start_ok, do_out;
	logic [16:0]           dem_v;
	logic signed [18:0]    target, lo, hi, lim;

	assign run_time   = item_s4.now - start_stamp_q;
	assign choke_trip = item_s4.choke_on && (run_time > TIME_WIDTH'(CHOKE_LIMIT_US));
	assign crank_long = (start_stamp_q != '0) && (run_time[31:0] > OVERHEAT_US);
	assign start_ok   = (start_stamp_q == '0) && item_s4.starter_on &&
	                    (item_s4.demand <= START_DEMAND_MAX);

	always_comb begin
		start_n    = start_stamp_q;
		overheat_n = overheat_q;
		power_n    = last_power_q;
		do_out     = 1'b0;
		dem_v      = item_s4.demand;
		target     = '0;
		lim        = '0;
		lo         = $signed({2'b00, last_power_q}) - $signed({2'b00, step_s4});
		hi         = $signed({2'b00, last_power_q}) + $signed({2'b00, step_s4});
		if (!cfg.starter_present) begin
			power_n = item_s4.demand;
		end else begin
			if (item_s4.ign_off) begin
				// cranking without ignition
				if (item_s4.starter_on) begin
					do_out = 1'b1;
					if (!cfg.gearbox_present)
						dem_v = CRANK_THRUST;
				end
			end else if (choke_trip) begin
				do_out = 1'b0;
			end else if (last_power_q == '0 && !item_s4.starter_on) begin
				do_out = 1'b0;
			end else begin
				if (start_ok)
					start_n = item_s4.now;
				if (start_n != '0 && item_s4.starter_on) begin
					if (crank_long)
						overheat_n = 1'b1;
				end else begin
					overheat_n = 1'b0;
				end
				do_out = 1'b1;
			end

			if (do_out) begin
				if (cfg.gearbox_present)
					target = item_s4.park ? 19'sd0 : $signed({2'b00, dem_v});
				else if (start_n != '0 && dem_v < IDLE_FLOOR)
					target = $signed({2'b00, IDLE_FLOOR});
				else
					target = $signed({2'b00, dem_v});
				if (target < lo)
					lim = lo;
				else if (target > hi)
					lim = hi;
				else
					lim = target;
				if (lim < 19'sd0)
					power_n = '0;
				else if (lim > $signed({2'b00, ONE_FX}))
					power_n = ONE_FX;
				else
					power_n = lim[16:0];
			end else begin
				start_n = '0;
				power_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_power_q  <= '0;
			start_stamp_q <= '0;
			overheat_q    <= 1'b0;
		end else if (load_out && v_s4) begin
			last_power_q  <= power_n;
			start_stamp_q <= start_n;
			overheat_q    <= overheat_n;
		end
	end

	logic [16:0] power_q;
	logic [12:0] rpm_q;
	logic        overheat_out_q, running_q;

	always_ff @(posedge clk) begin
		if (load_out && v_s4) begin
			power_q        <= power_n;
			rpm_q          <= rpm_s4;
			overheat_out_q <= overheat_n;
			running_q      <= (start_n != '0);
		end
	end

	assign result_valid = result_valid_q;
	assign power_out    = power_q;
	assign rpm          = rpm_q;
	assign overheat     = overheat_out_q;
	assign running      = running_q;

	// ---------------- assertions ----------------
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> power_q <= ONE_FX)
		else $error("power above full scale");

	a_rpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> rpm_q <= RPM_BASE + RPM_SPAN)
		else $error("rpm out of range");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> step_s4 <= ONE_FX)
		else $error("slew step above full scale");

	a_s4_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !load_out |=> v_s4)
		else $error("stage 4 transaction dropped while output stalled");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && result_valid_q)
		else $error("input stalled with a free stage");

endmodule

### test/engine_start_throttle_model_tb.sv
module engine_start_throttle_model_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import est_pkg::*;

	localparam int unsigned TW = TIME_WIDTH_DEF;
	localparam longint FULL_FX = longint'(ONE_FX);
	localparam longint CRANK_FX = longint'(CRANK_THRUST);
	localparam longint FLOOR_FX = longint'(IDLE_FLOOR);
	localparam longint unsigned SLEW_DIV = 64'd100000000;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned SUBPHASE_ITEMS = 200;

	typedef struct {
		logic [TW-1:0] now;
		logic [16:0]   dem;
		logic [11:0]   st_pwm;
		logic          st_ok;
		logic [11:0]   ig_pwm;
		logic          ig_ok;
		logic [11:0]   ch_pwm;
		logic          ch_ok;
		logic          pn;
	} tick_t;

	typedef struct {
		logic [16:0] power;
		logic [12:0] rpm;
		logic        hot;
		logic        run;
	} engine_out_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] val;
		tick_t       tk;
		logic        typed;
		engine_out_t want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [DATA_WIDTH-1:0] pwdata;
	logic [DATA_WIDTH-1:0] prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_stall;
	logic [TW-1:0]         now_us;
	logic [16:0]           demand;
	logic [11:0]           starter_pwm;
	logic                  starter_pwm_ok;
	logic [11:0]           ignition_pwm;
	logic                  ignition_pwm_ok;
	logic [11:0]           choke_pwm;
	logic                  choke_pwm_ok;
	logic                  park_or_neutral;
	logic                  result_valid;
	logic                  result_stall;
	logic [16:0]           power_out;
	logic [12:0]           rpm;
	logic                  overheat;
	logic                  running;

	engine_start_throttle_model #(.TIME_WIDTH(TW)) DUT (.*);

	// predictor copy of registers and engine state
	logic          cfg_rpm_fail;
	logic [13:0]   cfg_slew;
	logic          cfg_starter;
	logic          cfg_ign;
	logic          cfg_choke;
	logic          cfg_gear;
	longint        eng_power;
	logic [TW-1:0] eng_start;
	logic [TW-1:0] eng_last;
	logic          eng_hot;

	engine_out_t pending_results[$];
	plan_row_t   plan[$];
	int unsigned mismatches;
	int unsigned sender_gap_pct;
	int unsigned receiver_stall_pct;
	logic [TW-1:0] sim_now;
	int unsigned crank_left;

	function automatic engine_out_t predict_engine(input tick_t t);
		engine_out_t r;
		logic [TW-1:0] dt;
		logic [TW-1:0] since;
		longint unsigned prod;
		longint dem, step, lo, hi, v;
		logic ign_on, choke_on, crank_on, drive;
		dem = (t.dem > ONE_FX) ? FULL_FX : longint'(t.dem);
		r.rpm = cfg_rpm_fail ? '0 : RPM_BASE + 13'((dem * longint'(RPM_SPAN)) >>> 16);
		drive = 1'b0;
		if (!cfg_starter) begin
			eng_power = dem;
		end else begin
			dt = t.now - eng_last;
			if (cfg_slew == '0) begin
				step = 0;
			end else if (dt >= SLEW_DIV) begin
				step = FULL_FX;
			end else begin
				prod = 64'(cfg_slew) * 64'(dt);
				step = longint'((prod << 16) / SLEW_DIV);
				if (step > FULL_FX)
					step = FULL_FX;
			end
			ign_on = (cfg_ign && t.ig_ok) ? (t.ig_pwm > ON_THRESHOLD) : 1'b1;
			choke_on = (cfg_choke && t.ch_ok) ? (t.ch_pwm > ON_THRESHOLD) : 1'b0;
			crank_on = t.st_ok && (t.st_pwm > ON_THRESHOLD);
			since = t.now - eng_start;
			if (cfg_ign && !ign_on) begin
				// ignition off: only cranking keeps power up
				if (crank_on) begin
					if (!cfg_gear)
						dem = CRANK_FX;
					drive = 1'b1;
				end
			end else if (choke_on && since > CHOKE_LIMIT_US) begin
				drive = 1'b0;
			end else if (eng_power > 0 || crank_on) begin
				if (eng_start == '0 && crank_on && dem * 5 <= FULL_FX)
					eng_start = t.now;
				since = t.now - eng_start;
				if (eng_start != '0 && crank_on) begin
					if (since[31:0] > OVERHEAT_US)
						eng_hot = 1'b1;
				end else begin
					eng_hot = 1'b0;
				end
				drive = 1'b1;
			end
			if (drive) begin
				lo = eng_power - step;
				hi = eng_power + step;
				v = dem;
				if (cfg_gear) begin
					if (t.pn)
						v = 0;
				end else if (eng_start != '0 && v < FLOOR_FX) begin
					v = FLOOR_FX;
				end
				if (v < lo)
					v = lo;
				else if (v > hi)
					v = hi;
				if (v < 0)
					v = 0;
				if (v > FULL_FX)
					v = FULL_FX;
				eng_power = v;
			end else begin
				eng_start = '0;
				eng_power = 0;
			end
			eng_last = t.now;
		end
		r.power = 17'(eng_power);
		r.hot = eng_hot;
		r.run = (eng_start != '0);
		return r;
	endfunction

	function automatic tick_t tk(input logic [TW-1:0] now, input logic [16:0] dem,
			input logic [11:0] st, input logic st_ok, input logic [11:0] ig,
			input logic ig_ok, input logic [11:0] ch, input logic ch_ok, input logic pn);
		tick_t t;
		t.now = now;
		t.dem = dem;
		t.st_pwm = st;
		t.st_ok = st_ok;
		t.ig_pwm = ig;
		t.ig_ok = ig_ok;
		t.ch_pwm = ch;
		t.ch_ok = ch_ok;
		t.pn = pn;
		return t;
	endfunction

	function automatic plan_row_t tick_row(input tick_t t);
		plan_row_t p;
		p.kind = ROW_TICK;
		p.idx = REG_RPM_FAILURE;
		p.val = '0;
		p.tk = t;
		p.typed = 1'b0;
		p.want = '{default: '0};
		return p;
	endfunction

	// rows whose result is obvious: overheat and running stay low
	function automatic plan_row_t known_row(input tick_t t, input logic [16:0] pw,
			input logic [12:0] rp);
		plan_row_t p;
		p = tick_row(t);
		p.typed = 1'b1;
		p.want.power = pw;
		p.want.rpm = rp;
		return p;
	endfunction

	function automatic plan_row_t cfg_row(input reg_idx_t idx, input logic [31:0] v);
		plan_row_t p;
		p = tick_row(tk('0, '0, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0));
		p.kind = ROW_CFG;
		p.idx = idx;
		p.val = v;
		return p;
	endfunction

	function automatic logic [11:0] pwm_val(input logic on);
		int unsigned r;
		r = $urandom_range(19);
		if (r == 0)
			return on ? ON_THRESHOLD + 12'd1 : ON_THRESHOLD;
		return on ? 12'($urandom_range(4095, 1701)) : 12'($urandom_range(1700, 0));
	endfunction

	// mostly plausible timelines with cranking bursts, some noise
	function automatic tick_t gen_tick();
		tick_t t;
		int unsigned r;
		logic crank;
		r = $urandom_range(99);
		if (r < 12) begin
			t.now = TW'({$urandom, $urandom});
			if (r < 3)
				t.now[TW-1:12] = '1;
			else if (r < 6)
				t.now = sim_now - TW'($urandom_range(5000));
			t.dem = 17'($urandom);
			t.st_pwm = 12'($urandom);
			t.st_ok = 1'($urandom);
			t.ig_pwm = 12'($urandom);
			t.ig_ok = 1'($urandom);
			t.ch_pwm = 12'($urandom);
			t.ch_ok = 1'($urandom);
			t.pn = 1'($urandom);
			sim_now = t.now;
			return t;
		end
		if (crank_left == 0 && $urandom_range(7) == 0)
			crank_left = $urandom_range(40, 3);
		crank = (crank_left != 0);
		if (crank) begin
			crank_left--;
			sim_now += TW'($urandom_range(300000, 1));
		end else begin
			r = $urandom_range(9);
			sim_now += TW'(r < 5 ? $urandom_range(2000) :
				r < 9 ? $urandom_range(250000) : $urandom_range(1500000));
		end
		t.now = sim_now;
		r = $urandom_range(99);
		if (r < 3)
			t.dem = 17'($urandom_range(131071, 65537));
		else if (r < 6)
			t.dem = (r == 3) ? START_DEMAND_MAX : START_DEMAND_MAX + 17'd1;
		else if (crank && r < 70)
			t.dem = 17'($urandom_range(START_DEMAND_MAX));
		else
			t.dem = 17'($urandom_range(ONE_FX));
		t.st_pwm = pwm_val(crank || $urandom_range(19) == 0);
		t.st_ok = ($urandom_range(19) != 0);
		t.ig_pwm = pwm_val($urandom_range(9) != 0);
		t.ig_ok = ($urandom_range(9) != 0);
		t.ch_pwm = pwm_val($urandom_range(9) == 0);
		t.ch_ok = ($urandom_range(9) != 0);
		t.pn = 1'($urandom_range(1));
		return t;
	endfunction

	task automatic send_tick(input tick_t t, input logic typed, input engine_out_t known);
		engine_out_t guess;
		while ($urandom_range(99) < sender_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		now_us <= t.now;
		demand <= t.dem;
		starter_pwm <= t.st_pwm;
		starter_pwm_ok <= t.st_ok;
		ignition_pwm <= t.ig_pwm;
		ignition_pwm_ok <= t.ig_ok;
		choke_pwm <= t.ch_pwm;
		choke_pwm_ok <= t.ch_ok;
		park_or_neutral <= t.pn;
		do @(posedge clk); while (item_stall);
		guess = predict_engine(t);
		if (typed)
			pending_results.push_back(known);
		else
			pending_results.push_back(guess);
	endtask

	// register writes only once the pipeline has drained
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RPM_FAILURE: cfg_rpm_fail = v[0];
			REG_SLEW: cfg_slew = v[13:0];
			REG_STARTER_PRESENT: cfg_starter = v[0];
			REG_IGNITION_PRESENT: cfg_ign = v[0];
			REG_CHOKE_PRESENT: cfg_choke = v[0];
			REG_GEARBOX_PRESENT: cfg_gear = v[0];
			default: ;
		endcase
	endtask

	task automatic program_config(input logic rf, input logic [13:0] slew, input logic st,
			input logic ig, input logic ch, input logic gb);
		write_reg(REG_RPM_FAILURE, 32'(rf));
		write_reg(REG_SLEW, 32'(slew));
		write_reg(REG_STARTER_PRESENT, 32'(st));
		write_reg(REG_IGNITION_PRESENT, 32'(ig));
		write_reg(REG_CHOKE_PRESENT, 32'(ch));
		write_reg(REG_GEARBOX_PRESENT, 32'(gb));
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		$display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		engine_out_t want;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: expected no transaction, got power_out %0d rpm %0d",
						$time, power_out, rpm);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (power_out !== want.power)
						flag_mismatch("power_out", 64'(want.power), 64'(power_out));
					if (rpm !== want.rpm)
						flag_mismatch("rpm", 64'(want.rpm), 64'(rpm));
					if (overheat !== want.hot)
						flag_mismatch("overheat", 64'(want.hot), 64'(overheat));
					if (running !== want.run)
						flag_mismatch("running", 64'(want.run), 64'(running));
				end
			end
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel
					|| !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		engine_out_t blank;
		tick_t       t;
		blank = '{default: '0};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		now_us = '0;
		demand = '0;
		starter_pwm = '0;
		starter_pwm_ok = 1'b0;
		ignition_pwm = '0;
		ignition_pwm_ok = 1'b0;
		choke_pwm = '0;
		choke_pwm_ok = 1'b0;
		park_or_neutral = 1'b0;
		mismatches = 0;
		sender_gap_pct = 0;
		receiver_stall_pct = 0;
		sim_now = '0;
		crank_left = 0;
		cfg_rpm_fail = 1'b0;
		cfg_slew = SLEW_RESET;
		cfg_starter = 1'b0;
		cfg_ign = 1'b0;
		cfg_choke = 1'b0;
		cfg_gear = 1'b0;
		eng_power = 0;
		eng_start = '0;
		eng_last = '0;
		eng_hot = 1'b0;

		// no starter: power follows demand, demand saturates at one
		plan.push_back(known_row(tk(48'd0, 17'd0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd0, 1'b0,
			1'b0), 17'd0, 13'd1000));
		plan.push_back(known_row(tk(48'd1, ONE_FX, 12'd0, 1'b0, 12'd0, 1'b0, 12'd0, 1'b0,
			1'b0), ONE_FX, 13'd7000));
		plan.push_back(known_row(tk(48'd2, 17'h1FFFF, 12'hFFF, 1'b1, 12'hFFF, 1'b1, 12'hFFF,
			1'b1, 1'b1), ONE_FX, 13'd7000));
		plan.push_back(cfg_row(REG_RPM_FAILURE, 32'd1));
		plan.push_back(known_row(tk(48'd3, 17'd32768, 12'd0, 1'b0, 12'd0, 1'b0, 12'd0, 1'b0,
			1'b0), 17'd32768, 13'd0));
		plan.push_back(cfg_row(REG_RPM_FAILURE, 32'd0));
		plan.push_back(cfg_row(REG_STARTER_PRESENT, 32'd1));
		plan.push_back(cfg_row(REG_IGNITION_PRESENT, 32'd1));
		plan.push_back(cfg_row(REG_CHOKE_PRESENT, 32'd1));
		plan.push_back(cfg_row(REG_SLEW, 32'd10000));
		// crank at time zero: start stamp stays zero
		plan.push_back(tick_row(tk(48'd0, 17'd0, 12'd2000, 1'b1, 12'd2000, 1'b1, 12'd0, 1'b1,
			1'b0)));
		plan.push_back(tick_row(tk(48'd1000, 17'd0, 12'd2000, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(tick_row(tk(48'd200000, ONE_FX, 12'd1700, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		// ignition without pulse counts as on
		plan.push_back(tick_row(tk(48'd400000, ONE_FX, 12'd0, 1'b0, 12'd0, 1'b0, 12'd0, 1'b1,
			1'b0)));
		// choke held past one second stops the engine
		plan.push_back(tick_row(tk(48'd2000000, ONE_FX, 12'd0, 1'b0, 12'd2000, 1'b1, 12'd2000,
			1'b1, 1'b0)));
		// starter pulse missing counts as off
		plan.push_back(tick_row(tk(48'd2100000, ONE_FX, 12'd2000, 1'b0, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		// ignition off while cranking: crank thrust
		plan.push_back(tick_row(tk(48'd2200000, ONE_FX, 12'd2000, 1'b1, 12'd1000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(tick_row(tk(48'd2300000, ONE_FX, 12'd1000, 1'b1, 12'd1000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		// long crank raises overheat, releasing starter clears it
		plan.push_back(tick_row(tk(48'd2400000, 17'd0, 12'd2000, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(tick_row(tk(48'd4000000, 17'd0, 12'd2000, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(tick_row(tk(48'd5400001, 17'd0, 12'd2000, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(tick_row(tk(48'd5500000, 17'd30000, 12'd0, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(cfg_row(REG_GEARBOX_PRESENT, 32'd1));
		plan.push_back(tick_row(tk(48'd5600000, 17'd40000, 12'd0, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b1)));
		plan.push_back(tick_row(tk(48'd5700000, 17'd40000, 12'd0, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(cfg_row(REG_SLEW, 32'd0));
		plan.push_back(tick_row(tk(48'd5800000, ONE_FX, 12'd0, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(cfg_row(REG_SLEW, 32'd10000));
		// time stamp wraps
		plan.push_back(tick_row(tk({TW{1'b1}} - TW'(999), 17'd20000, 12'd0, 1'b1, 12'd2000,
			1'b1, 12'd0, 1'b1, 1'b0)));
		plan.push_back(tick_row(tk(48'd500, 17'd20000, 12'd0, 1'b1, 12'd2000, 1'b1, 12'd0,
			1'b1, 1'b0)));
		plan.push_back(cfg_row(REG_GEARBOX_PRESENT, 32'd0));
		plan.push_back(tick_row(tk({TW{1'b1}}, 17'h1FFFF, 12'hFFF, 1'b1, 12'hFFF, 1'b1,
			12'hFFF, 1'b1, 1'b1)));
		plan.push_back(tick_row(tk(48'd0, 17'd0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd0, 1'b0,
			1'b0)));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_tick(plan[i].tk, plan[i].typed, plan[i].want);
		end

		for (int sp = 0; sp < 8; sp++) begin
			case (sp / 2)
				0: begin
					sender_gap_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_gap_pct = 55;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_gap_pct = 0;
					receiver_stall_pct = 55;
				end
				default: begin
					sender_gap_pct = 31;
					receiver_stall_pct = 31;
				end
			endcase
			case (sp)
				0: program_config(1'b0, 14'd10000, 1'b1, 1'b1, 1'b1, 1'b0);
				1: program_config(1'b1, 14'd0, 1'b1, 1'b1, 1'b1, 1'b1);
				2: program_config(1'b0, 14'd1, 1'b1, 1'b0, 1'b0, 1'b0);
				3: program_config(1'b1, 14'd10000, 1'b0, 1'b1, 1'b1, 1'b1);
				default: program_config(1'($urandom_range(1)),
					14'($urandom_range(2) == 0 ? $urandom_range(100) : $urandom_range(10000)),
					1'($urandom_range(7) != 0), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			endcase
			repeat (SUBPHASE_ITEMS) begin
				t = gen_tick();
				send_tick(t, 1'b0, blank);
			end
		end

		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
design/est_pkg.sv
design/est_regs.sv
design/engine_start_throttle_model.sv
test/engine_start_throttle_model_tb.sv
